// ===== hdl/mavt_pkg.sv =====
// ----------------------------------------------------------------------------
// mavt_pkg: shared types and constants of the multi-turn angle tracker
// Field widths, register codes, queue entry and status structs, FSM states.
// ----------------------------------------------------------------------------
package mavt_pkg;

    // field widths
    localparam int FRAME_WIDTH = 16;
    localparam int COUNT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int TURNS_W     = 32;
    localparam int POS_W       = 48;
    localparam int VEL_W       = 40;
    localparam int RES_W       = 5;
    localparam int TOP_W       = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    // datapath widths
    localparam int DT_W       = 19;
    localparam int MAG_W      = 39;
    localparam int MUL_SPLIT  = 20;
    localparam int RATE_W     = 20;
    localparam int PROD_W     = 59;
    localparam int DIV_CNT_W  = 6;

    // queue sizing
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESOLUTION_BITS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TOP_BIT    = 1'b1;

    // register reset values and limits
    localparam logic [RES_W-1:0] RES_RESET = 5'd14;
    localparam logic [RES_W-1:0] RES_MAX   = 5'd16;
    localparam logic [TOP_W-1:0] TOP_RESET = 4'd13;

    localparam logic [FRAME_WIDTH-1:0] COUNT_MASK = 16'hFFFF;

    // jump test: |d| * 5 > 4 * counts per turn
    localparam logic [DT_W-1:0] JUMP_NUM = 19'd5;
    localparam logic [DT_W-1:0] JUMP_DEN = 19'd4;

    // elapsed time rules
    localparam logic [TIME_W-1:0] DT_LIMIT   = 32'd500000;
    localparam logic [DT_W-1:0]   DT_DEFAULT = 19'd1000;

    // velocity scaling and saturation
    localparam logic [RATE_W-1:0]  US_PER_S    = 20'd1000000;
    localparam logic [PROD_W-1:0]  VEL_POS_MAX = 59'h7F_FFFF_FFFF;
    localparam logic [PROD_W-1:0]  VEL_NEG_MAG = 59'h80_0000_0000;
    localparam logic [VEL_W-1:0]   VEL_SAT_POS = 40'h7F_FFFF_FFFF;
    localparam logic [VEL_W-1:0]   VEL_SAT_NEG = 40'h80_0000_0000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 6'd58;

    // request handed from front end to back end
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic [POS_W-1:0]   delta;
        logic [DT_W-1:0]    dt;
        logic               start;
    } mavt_entry_t;

    // queue status seen by both ends
    typedef struct packed {
        logic empty;
        logic full;
    } mavt_qstat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_UNWRAP,
        F_POSITION,
        F_PUSH
    } mavt_front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_DIV,
        B_DONE
    } mavt_back_state_t;

endpackage

// ===== hdl/mavt_if.sv =====
// ----------------------------------------------------------------------------
// mavt_if: request channels of the multi-turn angle tracker
// Valid/ready channels for sensor samples in and tracking results out.
// ----------------------------------------------------------------------------
interface mavt_in_if
    import mavt_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FRAME_WIDTH-1:0] frame;
    logic [TIME_W-1:0]      now_us;
    logic                   start_req;

    modport source (output valid, output frame, output now_us, output start_req,
                    input ready);
    modport sink   (input valid, input frame, input now_us, input start_req,
                    output ready);
endinterface

interface mavt_out_if
    import mavt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic [COUNT_W-1:0]       count;
    logic signed [VEL_W-1:0]  velocity;

    modport source (output valid, output position, output count, output velocity,
                    input ready);
    modport sink   (input valid, input position, input count, input velocity,
                    output ready);
endinterface

// ===== hdl/multiturn_angle_velocity_tracker.sv =====
// Back end steps per sample: pop, split multiply over low and high halves, partial
// product sum, 59-step restoring divider and result load; a start sample or an oversized
// position change skips the multiply and divider. It pops no new sample until loaded.
// The front end takes a new sample only after queueing the last, while the 2-entry queue has room.
// Reset: resolution_bits 14, data_top_bit 13, turns and last sample state zero,
// queue and result register empty.
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker: multi-turn angle and velocity tracker
// Unwraps sensor counts into a signed position and derives counts per second.
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker
    import mavt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mavt_in_if.sink                in_ch,
    mavt_out_if.source             out_ch
);

    logic        push;
    logic        pop;
    logic        load;
    mavt_entry_t push_entry;
    mavt_entry_t pop_entry;
    mavt_qstat_t qstat;

    // sample intake and unwrapping
    mavt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .push       (push),
        .push_entry (push_entry),
        .qstat      (qstat)
    );

    // request queue
    mavt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    // velocity math and result register
    mavt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_entry (pop_entry),
        .qstat     (qstat),
        .out_ch    (out_ch),
        .load      (load)
    );

`ifndef ASSERT_OFF
    // queue can never look empty and full at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.empty && qstat.full))
        else $error("queue status inconsistent");

    // front end takes one sample and then works on it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("sample taken while previous one in progress");

    // a finished result shows up on the output channel
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_ch.valid)
        else $error("result load lost");

    // back end pops only a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/mavt_front.sv =====
// ----------------------------------------------------------------------------
// mavt_front: sample intake and turn unwrapping
// Holds configuration and tracking state, extracts the count, unwraps turns,
// forms position, position change and elapsed time, and queues the request.
// ----------------------------------------------------------------------------
module mavt_front
    import mavt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mavt_in_if.sink                in_ch,
    output logic                   push,
    output mavt_entry_t            push_entry,
    input  mavt_qstat_t            qstat
);

    mavt_front_state_t state_reg, state_next;

    logic [RES_W-1:0]   res_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               start_reg, start_next;
    logic [COUNT_W-1:0] last_count_reg, last_count_next;
    logic [TURNS_W-1:0] turns_reg, turns_next;
    logic [POS_W-1:0]   last_pos_reg, last_pos_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic [DT_W-1:0]    dt_reg, dt_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [RES_W-1:0]       eff_res;
    logic signed [6:0]      shift_s;
    logic [4:0]             shift_u;
    logic [FRAME_WIDTH-1:0] mask;
    logic [COUNT_W-1:0]     count_new;
    logic signed [COUNT_W:0] d;
    logic [COUNT_W:0]       dmag;
    logic [DT_W-1:0]        dmag5;
    logic [DT_W-1:0]        cpr4;
    logic                   jump;
    logic [TIME_W-1:0]      dt_raw;
    logic                   accept;

    // effective resolution, shift and mask
    always_comb
    begin
        eff_res   = (res_reg > RES_MAX) ? RES_MAX : res_reg;
        shift_s   = $signed({3'b000, top_reg}) + 7'sd1 - $signed({2'b00, eff_res});
        shift_u   = shift_s[6] ? 5'd0 : shift_s[4:0];
        mask      = COUNT_MASK >> (RES_MAX - eff_res);
        count_new = (in_ch.frame >> shift_u) & mask;
    end

    // jump test and elapsed time
    always_comb
    begin
        d      = $signed({1'b0, cnt_reg}) - $signed({1'b0, last_count_reg});
        dmag   = d[COUNT_W] ? COUNT_W'(0) - d : d;
        dmag5  = DT_W'(dmag) * JUMP_NUM;
        cpr4   = JUMP_DEN << eff_res;
        jump   = dmag5 > cpr4;
        dt_raw = now_reg - last_time_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_ch.valid)
                    state_next = F_UNWRAP;
            end
            F_UNWRAP:   state_next = F_POSITION;
            F_POSITION: state_next = F_PUSH;
            F_PUSH:
            begin
                if (!qstat.full)
                    state_next = F_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ch.ready     = 1'b0;
        push            = 1'b0;
        accept          = 1'b0;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        start_next      = start_reg;
        last_count_next = last_count_reg;
        turns_next      = turns_reg;
        last_pos_next   = last_pos_reg;
        last_time_next  = last_time_reg;
        dt_next         = dt_reg;
        pos_next        = pos_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ch.ready = 1'b1;
                accept      = in_ch.valid;
                if (accept)
                begin
                    cnt_next   = count_new;
                    now_next   = in_ch.now_us;
                    start_next = in_ch.start_req;
                end
            end
            F_UNWRAP:
            begin
                if (start_reg)
                    turns_next = '0;
                else if (jump)
                    turns_next = d[COUNT_W] ? turns_reg + 1'b1 : turns_reg - 1'b1;
                last_count_next = cnt_reg;
                last_time_next  = now_reg;
                if (dt_raw == '0 || dt_raw > DT_LIMIT)
                    dt_next = DT_DEFAULT;
                else
                    dt_next = dt_raw[DT_W-1:0];
            end
            F_POSITION:
            begin
                pos_next = ({{(POS_W-TURNS_W){turns_reg[TURNS_W-1]}}, turns_reg} << eff_res)
                         + POS_W'(cnt_reg);
            end
            F_PUSH:
            begin
                push = !qstat.full;
                if (push)
                    last_pos_next = pos_reg;
            end
        endcase
    end

    // queued request
    always_comb
    begin
        push_entry.position = pos_reg;
        push_entry.count    = cnt_reg;
        push_entry.delta    = pos_reg - last_pos_reg;
        push_entry.dt       = dt_reg;
        push_entry.start    = start_reg;
    end

    // control, configuration and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            res_reg        <= RES_RESET;
            top_reg        <= TOP_RESET;
            last_count_reg <= '0;
            turns_reg      <= '0;
            last_pos_reg   <= '0;
            last_time_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_count_reg <= last_count_next;
            turns_reg      <= turns_next;
            last_pos_reg   <= last_pos_next;
            last_time_reg  <= last_time_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RESOLUTION_BITS: res_reg <= cfg_data[RES_W-1:0];
                    CFG_DATA_TOP_BIT:    top_reg <= cfg_data[TOP_W-1:0];
                endcase
            end
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        now_reg   <= now_next;
        start_reg <= start_next;
        dt_reg    <= dt_next;
        pos_reg   <= pos_next;
    end

endmodule

// ===== hdl/mavt_queue.sv =====
// ----------------------------------------------------------------------------
// mavt_queue: short request queue between front end and back end
// Small register FIFO so that intake and velocity math stall independently.
// ----------------------------------------------------------------------------
module mavt_queue
    import mavt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  mavt_entry_t push_entry,
    input  logic        pop,
    output mavt_entry_t pop_entry,
    output mavt_qstat_t qstat
);

    mavt_entry_t        entries_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] fill_reg, fill_next;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    assign qstat.empty = (fill_reg == '0);
    assign qstat.full  = (fill_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign pop_entry   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hdl/mavt_back.sv =====
// ----------------------------------------------------------------------------
// mavt_back: velocity computation and result register
// Splits the scaling multiply into low and high halves, runs a restoring divider one
// quotient bit per cycle, saturates and loads the output register.
// ----------------------------------------------------------------------------
module mavt_back
    import mavt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    output logic        pop,
    input  mavt_entry_t pop_entry,
    input  mavt_qstat_t qstat,
    mavt_out_if.source  out_ch,
    output logic        load
);

    mavt_back_state_t state_reg, state_next;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 start_reg, start_next;
    logic                 neg_reg, neg_next;
    logic                 big_reg, big_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [DT_W-1:0]      dt_reg, dt_next;
    logic [MAG_W:0]       pp_reg, pp_next;
    logic [PROD_W-1:0]    dvd_reg, dvd_next;
    logic [DT_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    logic                 out_valid_reg, out_valid_next;
    logic [POS_W-1:0]     out_pos_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [VEL_W-1:0]     out_vel_reg;

    logic [POS_W-1:0] mag48;
    logic             delta_neg;
    logic [DT_W:0]    trial;
    logic             ge;
    logic             pos_over;
    logic             neg_over;
    logic [VEL_W-1:0] vel;
    logic             out_free;

    // magnitude of the position change
    always_comb
    begin
        delta_neg = pop_entry.delta[POS_W-1];
        mag48     = delta_neg ? POS_W'(0) - pop_entry.delta : pop_entry.delta;
    end

    // divider step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[PROD_W-1]};
        ge    = trial >= {1'b0, dt_reg};
    end

    // saturation and sign
    always_comb
    begin
        pos_over = big_reg || (dvd_reg > VEL_POS_MAX);
        neg_over = big_reg || (dvd_reg > VEL_NEG_MAG);
        if (start_reg)
            vel = '0;
        else if (neg_reg)
            vel = neg_over ? VEL_SAT_NEG : VEL_W'(0) - dvd_reg[VEL_W-1:0];
        else
            vel = pos_over ? VEL_SAT_POS : dvd_reg[VEL_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (pop_entry.start || (|mag48[POS_W-1:MAG_W]))
                        state_next = B_DONE;
                    else
                        state_next = B_MUL_LO;
                end
            end
            B_MUL_LO: state_next = B_MUL_HI;
            B_MUL_HI: state_next = B_SUM;
            B_SUM:    state_next = B_DIV;
            B_DIV:
            begin
                if (step_reg == DIV_LAST)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop        = 1'b0;
        load       = 1'b0;
        pos_next   = pos_reg;
        count_next = count_reg;
        start_next = start_reg;
        neg_next   = neg_reg;
        big_next   = big_reg;
        mag_next   = mag_reg;
        dt_next    = dt_reg;
        pp_next    = pp_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                pop = !qstat.empty;
                if (pop)
                begin
                    pos_next   = pop_entry.position;
                    count_next = pop_entry.count;
                    start_next = pop_entry.start;
                    neg_next   = delta_neg;
                    big_next   = |mag48[POS_W-1:MAG_W];
                    mag_next   = mag48[MAG_W-1:0];
                    dt_next    = pop_entry.dt;
                end
            end
            B_MUL_LO:
            begin
                pp_next = (MAG_W+1)'(mag_reg[MUL_SPLIT-1:0]) * (MAG_W+1)'(US_PER_S);
            end
            B_MUL_HI:
            begin
                dvd_next = PROD_W'(pp_reg);
                pp_next  = (MAG_W+1)'(mag_reg[MAG_W-1:MUL_SPLIT]) * (MAG_W+1)'(US_PER_S);
            end
            B_SUM:
            begin
                dvd_next  = dvd_reg + (PROD_W'(pp_reg) << MUL_SPLIT);
                rem_next  = '0;
                step_next = '0;
            end
            B_DIV:
            begin
                rem_next  = ge ? DT_W'(trial - {1'b0, dt_reg}) : trial[DT_W-1:0];
                dvd_next  = {dvd_reg[PROD_W-2:0], ge};
                step_next = step_reg + 1'b1;
            end
            B_DONE:
            begin
                load = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // result register handshake
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.position = out_pos_reg;
    assign out_ch.count    = out_count_reg;
    assign out_ch.velocity = out_vel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        count_reg <= count_next;
        start_reg <= start_next;
        neg_reg   <= neg_next;
        big_reg   <= big_next;
        mag_reg   <= mag_next;
        dt_reg    <= dt_next;
        pp_reg    <= pp_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        if (load)
        begin
            out_pos_reg   <= pos_reg;
            out_count_reg <= count_reg;
            out_vel_reg   <= vel;
        end
    end

endmodule

// ===== dv/mavt_tracker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mavt_tracker_checker: result checker of the multi-turn angle tracker
// Watches both request channels and the register port, predicts every result
// from its own copy of the tracking state and compares it field by field.
// ----------------------------------------------------------------------------
module mavt_tracker_checker
    import mavt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mavt_in_if                     in_mon,
    mavt_out_if                    out_mon,
    output int                     errors,
    output int                     backlog
);

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic [VEL_W-1:0]   velocity;
    } track_result_t;

    // velocity limits and timing rules
    localparam logic [63:0]       RATE_CAP_POS  = 64'h7F_FFFF_FFFF;
    localparam logic [63:0]       RATE_CAP_NEG  = 64'h80_0000_0000;
    localparam logic [63:0]       RATE_OVER     = 64'h80_0000_0001;
    localparam logic [63:0]       US_SCALE      = 64'd1000000;
    localparam logic [TIME_W-1:0] MAX_GAP_US    = 32'd500000;
    localparam logic [TIME_W-1:0] FALLBACK_GAP  = 32'd1000;

    // shadow registers and tracking state
    logic [RES_W-1:0]   res_bits;
    logic [TOP_W-1:0]   top_bit;
    logic [COUNT_W-1:0] last_count;
    logic [TURNS_W-1:0] turns;
    logic [POS_W-1:0]   last_pos;
    logic [TIME_W-1:0]  last_time;

    track_result_t expected_q[$];
    track_result_t want;
    int            mismatch_total;

    // unwrap one sample and derive its rate, updating the tracking state
    function automatic track_result_t track_sample(input logic [FRAME_WIDTH-1:0] frame,
                                                   input logic [TIME_W-1:0] now,
                                                   input logic start);
        int unsigned        eff;
        int                 sh;
        int unsigned        shift;
        int unsigned        cpr;
        int                 d;
        int unsigned        dmag;
        logic [15:0]        mask;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  dt;
        logic [63:0]        wide_turns;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   delta;
        logic [POS_W-1:0]   mag;
        logic [63:0]        rate;
        track_result_t      r;

        eff   = (res_bits > RES_MAX) ? 16 : res_bits;
        sh    = 1 + int'(top_bit) - int'(eff);
        shift = (sh < 0) ? 0 : sh;
        mask  = 16'hFFFF >> (16 - eff);
        cnt   = (frame >> shift) & mask;
        cpr   = 1 << eff;

        // turn counter steps against a jump of more than 0.8 turn
        if (start)
            turns = '0;
        else
        begin
            d    = int'(cnt) - int'(last_count);
            dmag = (d < 0) ? -d : d;
            if (dmag * 5 > cpr * 4)
                turns = (d > 0) ? turns - 1'b1 : turns + 1'b1;
        end

        wide_turns = {{32{turns[TURNS_W-1]}}, turns};
        pos        = POS_W'((wide_turns << eff) + 64'(cnt));

        r.position = pos;
        r.count    = cnt;
        r.velocity = '0;

        // rate from position change over elapsed time
        if (!start)
        begin
            dt = now - last_time;
            if (dt == 0 || dt > MAX_GAP_US)
                dt = FALLBACK_GAP;
            delta = pos - last_pos;
            mag   = delta[POS_W-1] ? -delta : delta;
            if (64'(mag) >= RATE_CAP_NEG)
                rate = RATE_OVER;
            else
                rate = (64'(mag) * US_SCALE) / 64'(dt);
            if (delta[POS_W-1])
            begin
                if (rate > RATE_CAP_NEG)
                    rate = RATE_CAP_NEG;
                rate = -rate;
            end
            else if (rate > RATE_CAP_POS)
                rate = RATE_CAP_POS;
            r.velocity = rate[VEL_W-1:0];
        end

        last_count = cnt;
        last_pos   = pos;
        last_time  = now;
        return r;
    endfunction

    // register writes, result compare, then new sample requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bits       = RES_RESET;
            top_bit        = TOP_RESET;
            last_count     = '0;
            turns          = '0;
            last_pos       = '0;
            last_time      = '0;
            mismatch_total = 0;
            expected_q.delete();
            errors  <= 0;
            backlog <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RESOLUTION_BITS)
                    res_bits = cfg_data;
                else if (cfg_index == CFG_DATA_TOP_BIT)
                    top_bit = cfg_data[TOP_W-1:0];
            end

            // result request against the oldest expectation
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no sample outstanding: position %0d",
                           $signed(out_mon.position));
                    mismatch_total++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_mon.position !== want.position)
                    begin
                        $error("position mismatch: expected %0d, actual %0d",
                               $signed(want.position), $signed(out_mon.position));
                        mismatch_total++;
                    end
                    if (out_mon.count !== want.count)
                    begin
                        $error("count mismatch: expected %0d, actual %0d",
                               want.count, out_mon.count);
                        mismatch_total++;
                    end
                    if (out_mon.velocity !== want.velocity)
                    begin
                        $error("velocity mismatch: expected %0d, actual %0d",
                               $signed(want.velocity), $signed(out_mon.velocity));
                        mismatch_total++;
                    end
                end
            end

            // sample request accepted
            if (in_mon.valid && in_mon.ready)
                expected_q.push_back(track_sample(in_mon.frame, in_mon.now_us,
                                                  in_mon.start_req));

            errors  <= mismatch_total;
            backlog <= expected_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the multi-turn angle and velocity tracker
// Drives directed corner samples, then phases of rotating sensor samples over
// several register settings with random idling on both channels and one long
// receiver hold-off; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import mavt_pkg::*;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int IDLE_PCT        = 31;
    localparam int HOLD_CYCLES     = 600;
    localparam int STALL_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 100;
    localparam int BURST_PHASE     = 4;
    localparam int SQUEEZE_PHASE   = 2;

    typedef enum logic [1:0] {
        SPIN_FWD,
        SPIN_REV,
        WANDER
    } spin_t;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic [TOP_W-1:0] top;
        spin_t            spin;
    } phase_plan_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     backlog;

    mavt_in_if  in_ch ();
    mavt_out_if out_ch ();

    // sender view of the current setting and sensor motion
    logic [RES_W-1:0]  cur_res;
    logic [TOP_W-1:0]  cur_top;
    int unsigned       cur_count;
    logic [TIME_W-1:0] clock_us;
    bit                burst;
    bit                squeeze;
    bit                squeezed;
    int                stall;

    multiturn_angle_velocity_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mavt_tracker_checker track_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .errors    (errors),
        .backlog   (backlog)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic phase_plan_t plan_of(input int p);
        case (p)
            0:       return '{5'd14, 4'd13, WANDER};
            1:       return '{5'd8,  4'd7,  SPIN_FWD};
            2:       return '{5'd16, 4'd15, WANDER};
            3:       return '{5'd8,  4'd15, SPIN_REV};
            4:       return '{5'd12, 4'd11, WANDER};
            5:       return '{5'd16, 4'd7,  SPIN_REV};
            6:       return '{5'd10, 4'd12, SPIN_FWD};
            7:       return '{5'd31, 4'd15, WANDER};
            8:       return '{5'd9,  4'd8,  SPIN_FWD};
            default: return '{5'd13, 4'd14, WANDER};
        endcase
    endfunction

    function automatic int unsigned eff_bits();
        return (cur_res > RES_MAX) ? 16 : cur_res;
    endfunction

    // place a count in the data field, random bits elsewhere
    function automatic logic [15:0] pack_frame(input int unsigned cnt);
        int unsigned eff;
        int          sh;
        int unsigned shift;
        logic [15:0] field;
        eff   = eff_bits();
        sh    = 1 + int'(cur_top) - int'(eff);
        shift = (sh < 0) ? 0 : sh;
        field = (16'hFFFF >> (16 - eff)) << shift;
        return (16'($urandom) & ~field) | ((16'(cnt) << shift) & field);
    endfunction

    // elapsed time mix: zero, the limit and just past it, huge, short, normal
    function automatic logic [TIME_W-1:0] next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 14)
            return 32'd500000;
        if (r < 18)
            return 32'd500001;
        if (r < 23)
            return $urandom_range(500002, 32'hFFFF_FFFF);
        if (r < 35)
            return $urandom_range(1, 8);
        if (r < 85)
            return $urandom_range(9, 5000);
        return $urandom_range(5001, 499999);
    endfunction

    // next sensor count: steady motion, jumps near the wrap threshold, noise
    function automatic int unsigned next_count(input spin_t spin);
        int unsigned cpr;
        int unsigned span;
        int unsigned b;
        int          r;
        cpr = 1 << eff_bits();
        r   = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(0, cpr - 1);
        if (r < 14)
        begin
            b = (4 * cpr) / 5 + $urandom_range(0, 1);
            if (cur_count + b < cpr)
                return cur_count + b;
            if (cur_count >= b)
                return cur_count - b;
            return 0;
        end
        span = (r < 60) ? $urandom_range(0, cpr / 6) : $urandom_range(0, (cpr * 3) / 5);
        if (spin == SPIN_REV || (spin == WANDER && $urandom_range(0, 1) == 1))
            return (cur_count + cpr - span) % cpr;
        return (cur_count + span) % cpr;
    endfunction

    // offer one sample request, idling at random first
    task automatic offer(input logic [15:0] frame, input logic [TIME_W-1:0] now,
                         input logic start);
        while (!burst && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.frame     <= frame;
        in_ch.now_us    <= now;
        in_ch.start_req <= start;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic offer_count(input int unsigned cnt, input logic [TIME_W-1:0] gap,
                               input logic start);
        clock_us  = clock_us + gap;
        cur_count = cnt;
        offer(pack_frame(cnt), clock_us, start);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [RES_W-1:0] res, input logic [TOP_W-1:0] top);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RESOLUTION_BITS;
        cfg_data  <= res;
        @(posedge clk);
        cfg_index <= CFG_DATA_TOP_BIT;
        cfg_data  <= CFG_DATA_W'(top);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_res  = res;
        cur_top  = top;
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        squeezed     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeezed)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeezed = 1'b1;
            end
            else
                out_ch.ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no request moving
    initial
    begin
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall = 0;
            else
                stall++;
        end
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin
        phase_plan_t       plan;
        logic [TIME_W-1:0] gap;
        logic              start;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RESOLUTION_BITS;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.frame     = '0;
        in_ch.now_us    = '0;
        in_ch.start_req = 1'b0;
        cur_res         = RES_RESET;
        cur_top         = TOP_RESET;
        cur_count       = 0;
        clock_us        = '0;
        burst           = 1'b0;
        squeeze         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: seed, full frame, time limits, jump threshold
        offer_count(0, 100, 1'b1);
        offer(16'hFFFF, clock_us, 1'b0);
        cur_count = 16383;
        offer_count(0, 500000, 1'b0);
        offer_count(13107, 500001, 1'b0);
        offer_count(0, 7, 1'b0);
        offer_count(13108, 1, 1'b0);
        offer_count(0, 1, 1'b0);

        // timestamp wrap, then seed at the top of every field
        clock_us = 32'hFFFF_FE00;
        offer_count(9000, 256, 1'b0);
        offer_count(200, 512, 1'b0);
        clock_us = 32'hFFFF_FFFF;
        offer(16'hFFFF, clock_us, 1'b1);
        clock_us  = '0;
        cur_count = 0;
        offer(16'h0000, clock_us, 1'b0);

        // full width field
        drain();
        configure(5'd16, 4'd15);
        offer_count(65535, 3, 1'b0);
        offer_count(0, 3, 1'b0);
        offer_count(40000, 2, 1'b0);

        // narrowest field at the bottom
        drain();
        configure(5'd8, 4'd7);
        offer_count(255, 1, 1'b0);
        offer_count(0, 1, 1'b0);

        // resolution beyond 16 bits
        drain();
        configure(5'd31, 4'd15);
        offer_count(65535, 5, 1'b0);
        offer_count(1, 5, 1'b0);

        // negative shift
        drain();
        configure(5'd16, 4'd7);
        offer_count(12345, 9, 1'b0);
        offer_count(54321, 9, 1'b0);

        // widest shift
        drain();
        configure(5'd8, 4'd15);
        offer_count(200, 4, 1'b0);
        offer_count(17, 4, 1'b1);

        // random phases of rotating sensor samples
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            plan = plan_of(p);
            drain();
            configure(plan.res, plan.top);
            cur_count = cur_count % (1 << eff_bits());
            burst     = (p == BURST_PHASE);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == SQUEEZE_PHASE && i == 10)
                    squeeze = 1'b1;
                gap   = (i == 0) ? $urandom_range(1, 20) : next_gap();
                start = (i != 0 && plan.spin == WANDER && $urandom_range(0, 99) < 2);
                offer_count(next_count(plan.spin), gap, start);
            end
        end

        drain();
        burst = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mavt_pkg.sv
hdl/mavt_if.sv
hdl/mavt_front.sv
hdl/mavt_queue.sv
hdl/mavt_back.sv
hdl/multiturn_angle_velocity_tracker.sv
dv/mavt_tracker_checker.sv
dv/tb_top.sv
